// ----- rtl/rti_pkg.sv -----
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants of the rectilinear trilinear interpolator.
// ----------------------------------------------------------------------------
package rti_pkg;

   // transaction opcodes
   localparam logic [1:0] OP_LOAD_AXIS = 2'd0;
   localparam logic [1:0] OP_LOAD_NODE = 2'd1;
   localparam logic [1:0] OP_QUERY     = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_DIM_X = 2'd0;
   localparam logic [1:0] CSR_DIM_Y = 2'd1;
   localparam logic [1:0] CSR_DIM_Z = 2'd2;

   // axis selects
   localparam logic [1:0] AX_X = 2'd0;
   localparam logic [1:0] AX_Y = 2'd1;
   localparam logic [1:0] AX_Z = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BOUND,
      ST_SEARCH,
      ST_FRAC_RD,
      ST_DIV,
      ST_ADDR,
      ST_NODE_RD,
      ST_BLEND,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/rti_ram.sv -----
// ----------------------------------------------------------------------------
// rti_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/rectilinear_trilinear_interpolator.sv -----
// ----------------------------------------------------------------------------
// rectilinear_trilinear_interpolator
// Loads axis coordinates and node vectors, answers trilinear queries.
// ----------------------------------------------------------------------------
// Load transactions write the stores directly and give no result. A query
// runs on one sequencer: three bound checks, three binary searches with one
// axis RAM read per step, up to three 17-step restoring divisions for the
// fractions, and eight node reads followed by seven blends per component on
// one shared multiplier; busy is high for the whole query. A rejected query
// (small grid or outside point) skips the searches, divisions and blends.
// The result appears for one cycle with rsp_valid; it cannot be held.
module rectilinear_trilinear_interpolator #(
   parameter int AXIS_POINTS = 32,
   parameter int GRID_POINTS = 32768
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [1:0]         req_axis_select,
   input  logic [4:0]         req_axis_index,
   input  logic signed [31:0] req_coord_value,
   input  logic [14:0]        req_node_index,
   input  logic signed [31:0] req_node_vx,
   input  logic signed [31:0] req_node_vy,
   input  logic signed [31:0] req_node_vz,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_out_vx,
   output logic signed [31:0] rsp_out_vy,
   output logic signed [31:0] rsp_out_vz,
   output logic               rsp_in_range,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [5:0]         csr_data
);

   localparam int AW = $clog2(AXIS_POINTS);
   localparam int GW = $clog2(GRID_POINTS);
   localparam int DW = $clog2(AXIS_POINTS + 1);

   // configuration registers
   logic [5:0] dim_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff[0] <= '0;
         dim_ff[1] <= '0;
         dim_ff[2] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            rti_pkg::CSR_DIM_X: dim_ff[0] <= csr_data;
            rti_pkg::CSR_DIM_Y: dim_ff[1] <= csr_data;
            rti_pkg::CSR_DIM_Z: dim_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // effective dimensions
   logic [DW-1:0] nd [3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (32'(dim_ff[a]) > 32'(AXIS_POINTS)) nd[a] = DW'(AXIS_POINTS);
         else nd[a] = DW'(dim_ff[a]);
      end
   end

   // sequencer state
   rti_pkg::state_type state_ff, state_in;
   logic [1:0]         axis_ff, axis_in;
   logic [DW-1:0]      lo_ff, lo_in, hi_ff, hi_in;
   logic [2:0]         step_ff, step_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [2:0]         node_ff, node_in;
   logic [1:0]         comp_ff, comp_in;
   logic [AW-1:0]      base_ff [3];
   logic [AW-1:0]      base_in [3];
   logic [16:0]        frac_ff [3];
   logic [16:0]        frac_in [3];
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [32:0] c0_ff, c0_in;
   logic [32:0]        rem_ff, rem_in, den_ff, den_in;
   logic [16:0]        quo_ff, quo_in;
   logic signed [31:0] val_ff [8];
   logic signed [31:0] val_in [8];
   logic signed [31:0] res_ff [3];
   logic signed [31:0] res_in [3];
   logic               rv_ff, rv_in, rr_ff, rr_in;

   // axis stores: one RAM per axis, read address shared
   logic [AW-1:0]      ax_rd_addr;
   logic [31:0]        ax_rd [3];
   logic               ax_we [3];
   logic               load_ok;
   assign load_ok = 32'(req_axis_index) < 32'(AXIS_POINTS);

   for (genvar g = 0; g < 3; g++) begin : g_axis
      assign ax_we[g] = start && !busy && req_opcode == rti_pkg::OP_LOAD_AXIS &&
                        load_ok && req_axis_select == 2'(g);
      rti_ram #(.WIDTH(32), .DEPTH(AXIS_POINTS)) u_axis (
         .clock  (clock),
         .wr_en  (ax_we[g]),
         .wr_addr(AW'(req_axis_index)),
         .wr_data(req_coord_value),
         .rd_addr(ax_rd_addr),
         .rd_data(ax_rd[g])
      );
   end

   // node vector stores
   logic          nd_we;
   logic [GW-1:0] nd_rd_addr;
   logic [31:0]   nd_rd [3];
   logic [31:0]   nd_wdata [3];
   assign nd_we = start && !busy && req_opcode == rti_pkg::OP_LOAD_NODE &&
                  32'(req_node_index) < 32'(GRID_POINTS);
   assign nd_wdata[0] = req_node_vx;
   assign nd_wdata[1] = req_node_vy;
   assign nd_wdata[2] = req_node_vz;

   for (genvar g = 0; g < 3; g++) begin : g_node
      rti_ram #(.WIDTH(32), .DEPTH(GRID_POINTS)) u_node (
         .clock  (clock),
         .wr_en  (nd_we),
         .wr_addr(GW'(req_node_index)),
         .wr_data(nd_wdata[g]),
         .rd_addr(nd_rd_addr),
         .rd_data(nd_rd[g])
      );
   end

   // registered address arithmetic for node reads
   logic [GW-1:0] naddr_ff, naddr_in;

   // helper values
   logic signed [31:0] cur_ax, cur_pos;
   logic [DW-1:0]      mid;
   logic [DW:0]        lo_m1;
   logic [33:0]        trial;
   logic signed [32:0] diff;
   logic signed [50:0] prod;
   logic signed [31:0] bl_a, bl_b;
   logic [16:0]        bl_f;
   logic signed [31:0] bl_out;
   logic [2:0]         bi, bj, bk;

   always_comb begin
      unique case (axis_ff)
         2'd1:    cur_ax = ax_rd[1];
         2'd2:    cur_ax = ax_rd[2];
         default: cur_ax = ax_rd[0];
      endcase
      unique case (axis_ff)
         2'd1:    cur_pos = pos_ff[1];
         2'd2:    cur_pos = pos_ff[2];
         default: cur_pos = pos_ff[0];
      endcase
   end

   assign mid   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_m1 = {1'b0, lo_ff} - 1'b1;
   assign trial = {rem_ff, 1'b0} - {1'b0, den_ff};

   // blend operand selection: steps 0..3 along x, 4..5 along y, 6 along z
   always_comb begin
      bi = 3'd0;
      bj = 3'd1;
      bl_f = frac_ff[0];
      unique case (step_ff)
         3'd0: begin bi = 3'd0; bj = 3'd1; bl_f = frac_ff[0]; end
         3'd1: begin bi = 3'd2; bj = 3'd3; bl_f = frac_ff[0]; end
         3'd2: begin bi = 3'd4; bj = 3'd5; bl_f = frac_ff[0]; end
         3'd3: begin bi = 3'd6; bj = 3'd7; bl_f = frac_ff[0]; end
         3'd4: begin bi = 3'd0; bj = 3'd2; bl_f = frac_ff[1]; end
         3'd5: begin bi = 3'd4; bj = 3'd6; bl_f = frac_ff[1]; end
         3'd6: begin bi = 3'd0; bj = 3'd4; bl_f = frac_ff[2]; end
         default: begin bi = 3'd0; bj = 3'd0; bl_f = frac_ff[2]; end
      endcase
      bk   = bi;
      bl_a = val_ff[bi];
      bl_b = val_ff[bj];
   end

   // shared blend unit: a + floor((b - a) * f / 65536)
   assign diff   = 33'(bl_b) - 33'(bl_a);
   assign prod   = 51'(diff) * $signed({1'b0, bl_f});
   assign bl_out = 32'(33'(bl_a) + 33'(prod >>> 16));

   // next state and datapath control
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      node_in  = node_ff;
      comp_in  = comp_ff;
      c0_in    = c0_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      naddr_in = naddr_ff;
      rv_in    = 1'b0;
      rr_in    = rr_ff;
      for (int a = 0; a < 3; a++) begin
         base_in[a] = base_ff[a];
         frac_in[a] = frac_ff[a];
         pos_in[a]  = pos_ff[a];
         res_in[a]  = res_ff[a];
      end
      for (int n = 0; n < 8; n++) val_in[n] = val_ff[n];
      ax_rd_addr = '0;
      nd_rd_addr = naddr_ff;

      unique case (state_ff)
         rti_pkg::ST_IDLE: begin
            if (start && req_opcode == rti_pkg::OP_QUERY) begin
               pos_in[0] = req_pos_x;
               pos_in[1] = req_pos_y;
               pos_in[2] = req_pos_z;
               axis_in   = 2'd0;
               step_in   = 3'd0;
               for (int a = 0; a < 3; a++) res_in[a] = '0;
               rr_in     = 1'b0;
               if (nd[0] <= DW'(1) || nd[1] <= DW'(1) || nd[2] <= DW'(1)) begin
                  state_in = rti_pkg::ST_DONE;
               end else begin
                  state_in = rti_pkg::ST_BOUND;
               end
            end
         end

         // bound check: step 0 reads first, step 1 reads last and checks first, step 2 checks last
         rti_pkg::ST_BOUND: begin
            if (step_ff == 3'd0) ax_rd_addr = '0;
            else ax_rd_addr = AW'(nd[axis_ff] - DW'(1));
            unique case (step_ff)
               3'd0: step_in = 3'd1;
               3'd1: begin
                  step_in = 3'd2;
                  if (cur_pos < cur_ax) state_in = rti_pkg::ST_DONE;
               end
               default: begin
                  if (cur_pos > cur_ax) begin
                     state_in = rti_pkg::ST_DONE;
                  end else if (axis_ff == 2'd2) begin
                     axis_in  = 2'd0;
                     lo_in    = '0;
                     hi_in    = nd[0];
                     step_in  = 3'd0;
                     state_in = rti_pkg::ST_SEARCH;
                  end else begin
                     axis_in = axis_ff + 2'd1;
                     step_in = 3'd0;
                  end
               end
            endcase
         end

         // binary upper-bound search: step 0 issues a read, step 1 compares
         rti_pkg::ST_SEARCH: begin
            ax_rd_addr = AW'(mid);
            if (lo_ff >= hi_ff) begin
               if (lo_ff == '0) base_in[axis_ff] = '0;
               else if (lo_m1 > {1'b0, nd[axis_ff] - DW'(2)})
                  base_in[axis_ff] = AW'(nd[axis_ff] - DW'(2));
               else base_in[axis_ff] = AW'(lo_m1);
               if (axis_ff == 2'd2) begin
                  axis_in = 2'd0;
               end else begin
                  axis_in = axis_ff + 2'd1;
                  lo_in   = '0;
                  hi_in   = nd[axis_ff + 2'd1];
               end
               step_in = 3'd0;
               if (axis_ff == 2'd2) state_in = rti_pkg::ST_FRAC_RD;
            end else if (step_ff == 3'd0) begin
               step_in = 3'd1;
            end else begin
               step_in = 3'd0;
               if (cur_ax <= cur_pos) lo_in = mid + DW'(1);
               else hi_in = mid;
            end
         end

         // read c0 then c1 of the current axis, set up the division
         rti_pkg::ST_FRAC_RD: begin
            if (step_ff == 3'd0) ax_rd_addr = base_ff[axis_ff];
            else ax_rd_addr = base_ff[axis_ff] + AW'(1);
            unique case (step_ff)
               3'd0: step_in = 3'd1;
               3'd1: begin
                  c0_in   = 33'(cur_ax);
                  step_in = 3'd2;
               end
               default: begin
                  step_in = 3'd0;
                  if (33'(cur_ax) > c0_ff && 33'(cur_pos) > c0_ff) begin
                     rem_in   = 33'(33'(cur_pos) - c0_ff);
                     den_in   = 33'(33'(cur_ax) - c0_ff);
                     quo_in   = '0;
                     cnt_in   = 5'd0;
                     state_in = rti_pkg::ST_DIV;
                  end else begin
                     frac_in[axis_ff] = '0;
                     if (axis_ff == 2'd2) begin
                        node_in  = 3'd0;
                        state_in = rti_pkg::ST_ADDR;
                     end else begin
                        axis_in = axis_ff + 2'd1;
                     end
                  end
               end
            endcase
         end

         // restoring division: num * 65536 / den, one quotient bit a cycle
         rti_pkg::ST_DIV: begin
            if (cnt_ff == 5'd0) begin
               cnt_in = 5'd1;
               // first bit: integer part (num <= den, so quotient < 2^17)
               if (rem_ff >= den_ff) begin
                  rem_in = rem_ff - den_ff;
                  quo_in = 17'd1;
               end else begin
                  quo_in = 17'd0;
               end
            end else begin
               if (!trial[33]) begin
                  rem_in = trial[32:0];
                  quo_in = {quo_ff[15:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[31:0], 1'b0};
                  quo_in = {quo_ff[15:0], 1'b0};
               end
               if (cnt_ff == 5'd16) begin
                  frac_in[axis_ff] = trial[33] ? {quo_ff[15:0], 1'b0} :
                                                 {quo_ff[15:0], 1'b1};
                  if (quo_ff[16] && quo_ff[15:0] != '0) frac_in[axis_ff] = 17'h10000;
                  if (axis_ff == 2'd2) begin
                     node_in  = 3'd0;
                     state_in = rti_pkg::ST_ADDR;
                  end else begin
                     axis_in  = axis_ff + 2'd1;
                     state_in = rti_pkg::ST_FRAC_RD;
                  end
               end else begin
                  cnt_in = cnt_ff + 5'd1;
               end
            end
         end

         // linear address of the current corner, registered
         rti_pkg::ST_ADDR: begin
            naddr_in = GW'(32'(base_ff[0]) + 32'(node_ff[0]) +
                       (32'(base_ff[1]) + 32'(node_ff[1])) * 32'(nd[0]) +
                       (32'(base_ff[2]) + 32'(node_ff[2])) *
                       (32'(nd[0]) * 32'(nd[1])));
            step_in  = 3'd0;
            state_in = rti_pkg::ST_NODE_RD;
         end

         // read one corner of the current component
         rti_pkg::ST_NODE_RD: begin
            if (step_ff == 3'd0) begin
               step_in = 3'd1;
            end else begin
               unique case (comp_ff)
                  2'd1:    val_in[node_ff] = nd_rd[1];
                  2'd2:    val_in[node_ff] = nd_rd[2];
                  default: val_in[node_ff] = nd_rd[0];
               endcase
               if (node_ff == 3'd7) begin
                  step_in  = 3'd0;
                  state_in = rti_pkg::ST_BLEND;
               end else begin
                  node_in  = node_ff + 3'd1;
                  state_in = rti_pkg::ST_ADDR;
               end
            end
         end

         // seven blends through the shared multiplier
         rti_pkg::ST_BLEND: begin
            val_in[bk] = bl_out;
            if (step_ff == 3'd6) begin
               res_in[comp_ff] = bl_out;
               node_in = 3'd0;
               step_in = 3'd0;
               if (comp_ff == 2'd2) begin
                  comp_in  = 2'd0;
                  rr_in    = 1'b1;
                  state_in = rti_pkg::ST_DONE;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = rti_pkg::ST_ADDR;
               end
            end else begin
               step_in = step_ff + 3'd1;
            end
         end

         rti_pkg::ST_DONE: begin
            rv_in    = 1'b1;
            comp_in  = 2'd0;
            state_in = rti_pkg::ST_IDLE;
         end

         default: state_in = rti_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rti_pkg::ST_IDLE;
         rv_ff    <= 1'b0;
         axis_ff  <= '0;
         step_ff  <= '0;
         comp_ff  <= '0;
         node_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         axis_ff  <= axis_in;
         step_ff  <= step_in;
         comp_ff  <= comp_in;
         node_ff  <= node_in;
         cnt_ff   <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      c0_ff    <= c0_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
      naddr_ff <= naddr_in;
      rr_ff    <= rr_in;
      for (int a = 0; a < 3; a++) begin
         base_ff[a] <= base_in[a];
         frac_ff[a] <= frac_in[a];
         pos_ff[a]  <= pos_in[a];
         res_ff[a]  <= res_in[a];
      end
      for (int n = 0; n < 8; n++) val_ff[n] <= val_in[n];
   end

   assign busy         = state_ff != rti_pkg::ST_IDLE;
   assign rsp_valid    = rv_ff;
   assign rsp_out_vx   = res_ff[0];
   assign rsp_out_vy   = res_ff[1];
   assign rsp_out_vz   = res_ff[2];
   assign rsp_in_range = rr_ff;

   // result strobe only follows the finishing state
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == rti_pkg::ST_DONE)
      else $error("result strobe without finishing state");

   // an out-of-range result carries a zero vector
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_out_vx == 0 && rsp_out_vy == 0 &&
                                     rsp_out_vz == 0)
      else $error("nonzero vector on out-of-range result");

   // fractions never exceed one
   a_frac_max: assert property (@(posedge clock) disable iff (reset)
      state_ff == rti_pkg::ST_BLEND |-> frac_ff[0] <= 17'h10000 &&
         frac_ff[1] <= 17'h10000 && frac_ff[2] <= 17'h10000)
      else $error("fraction above one");

endmodule
